/* hdl/fasca_pkg.sv */
// Shared types and codes for the frame allocator with second-chance and aging replacement.
`timescale 1ns / 1ps

package fasca_pkg;

  localparam int REQ_W   = 2;
  localparam int INDEX_W = 6;
  localparam int KIND_W  = 2;
  localparam int OWNER_W = 6;
  localparam int VPAGE_W = 20;
  localparam int AGEV_W  = 16;
  localparam int STAT_W  = 2;
  localparam int POL_W   = 2;

  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MARK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_AGE     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd3;

  localparam logic [STAT_W-1:0] ST_FREE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_VICTIM = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_ACK    = 2'd3;

  localparam logic [POL_W-1:0] POL_SC  = 2'd0;
  localparam logic [POL_W-1:0] POL_AGE = 2'd1;

  localparam logic [KIND_W-1:0] KIND_PAGE = 2'd0;

  typedef enum logic [7:0] {
    S_CLR    = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_SWEEP  = 8'b0001_0000,
    S_VREAD  = 8'b0010_0000,
    S_OPRD   = 8'b0100_0000,
    S_COMMIT = 8'b1000_0000
  } state_t;

endpackage

/* hdl/fasca_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module fasca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/frame_allocator_second_chance_aging_core.sv */
// Top level of the physical frame allocator with second-chance and aging replacement.
//
// Requests arrive as beats on the s_ channel and each one returns exactly one result beat
// on the m_ channel. The replacement policy is written through the APB port at address 0.
// The frame table lives in one RAM with a registered read, walked by a single sequencer
// with one age comparator. An allocate request scans frames from 0 and stops at the first
// unused one. On a full table the scan covers every frame, and under second-chance
// replacement a pass that clears referenced bits may follow; then come the decision, a
// victim read where a victim is chosen, and the commit. Mark, load-age and release requests
// read their entry and then commit. The block takes one request at a time; s_tready is high
// only while it waits for a new request. After reset the block clears every table entry
// with s_tready low; APB writes are taken at any time. A finished result waits in the output
// register, and the block accepts the next request meanwhile; it holds its next result until
// the receiver takes the previous one.
`timescale 1ns / 1ps

module frame_allocator_second_chance_aging_core
  import fasca_pkg::*;
#(
  parameter int FRAMES   = 64,
  parameter int AGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // frame_index, frame_kind, pinned, owner_id, virtual_page, age_value, zero fill
  input  logic [55:0] s_tdata,
  // req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_frame, evicted_owner, evicted_page
  output logic [31:0] m_tdata,
  // status
  output logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW      = $clog2(FRAMES);
  localparam int REF_BIT = 4;
  localparam int AGE_LO  = 5;
  localparam int OWN_LO  = AGE_LO + AGE_BITS;
  localparam int VPG_LO  = OWN_LO + OWNER_W;
  localparam int EW      = VPG_LO + VPAGE_W;
  localparam logic [IW:0] FRAMES_W = (IW+1)'(FRAMES);
  localparam logic [IW:0] LAST_W   = (IW+1)'(FRAMES - 1);

  state_t state, state_next;

  logic [POL_W-1:0]    policy;
  logic [IW:0]         cnt;
  logic                d_valid;
  logic [IW-1:0]       d_idx;
  logic                free_found, cand_found, sc_found, ag_found;
  logic [IW-1:0]       free_idx, first_idx, sc_idx, ag_idx, pick;
  logic [AGE_BITS-1:0] ag_age;
  logic [STAT_W-1:0]   status_r;
  logic [IW:0]         clr_end;

  logic [REQ_W-1:0]    req_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [KIND_W-1:0]   kind_r;
  logic                pin_r;
  logic [OWNER_W-1:0]  owner_r;
  logic [VPAGE_W-1:0]  vpage_r;
  logic [AGEV_W-1:0]   agev_r;

  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [EW-1:0]       ram_wdata, rdata;

  logic                r_used, r_pin, r_ref, r_cand;
  logic [KIND_W-1:0]   r_kind;
  logic [AGE_BITS-1:0] r_age;
  logic [OWNER_W-1:0]  r_owner;
  logic [VPAGE_W-1:0]  r_vpage;

  logic                accept, slot_free, commit, is_alloc, idx_ok, sweep_last;
  logic [IW-1:0]       idx_addr;
  logic [IW:0]         sc_end;
  logic [EW-1:0]       alloc_entry, mark_entry, age_entry, commit_entry;

  fasca_ram #(.WIDTH(EW), .DEPTH(FRAMES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign r_used  = rdata[0];
  assign r_kind  = rdata[2:1];
  assign r_pin   = rdata[3];
  assign r_ref   = rdata[REF_BIT];
  assign r_age   = rdata[OWN_LO-1:AGE_LO];
  assign r_owner = rdata[VPG_LO-1:OWN_LO];
  assign r_vpage = rdata[EW-1:VPG_LO];
  assign r_cand  = r_used && !r_pin && (r_kind == KIND_PAGE);

  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? 32'd0 : {30'd0, policy};
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign commit    = (state == S_COMMIT) && slot_free;
  assign is_alloc  = (req_r == REQ_ALLOC);
  assign idx_ok    = 32'(idx_r) < FRAMES;
  assign idx_addr  = IW'(idx_r);
  assign sc_end    = sc_found ? {1'b0, sc_idx} : FRAMES_W;
  assign sweep_last = d_valid && ({1'b0, d_idx} == clr_end - (IW+1)'(1));

  assign alloc_entry = {vpage_r, owner_r, {AGE_BITS{1'b0}}, 1'b0, pin_r, kind_r, 1'b1};
  assign mark_entry  = rdata | (EW'(1) << REF_BIT);
  assign age_entry   = {rdata[EW-1:OWN_LO], AGE_BITS'(agev_r), rdata[AGE_LO-1:0]};

  always_comb begin
    unique case (req_r)
      REQ_ALLOC:   commit_entry = alloc_entry;
      REQ_MARK:    commit_entry = mark_entry;
      REQ_AGE:     commit_entry = age_entry;
      REQ_RELEASE: commit_entry = '0;
      default:     commit_entry = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = cnt[IW-1:0];
    ram_we     = 1'b0;
    ram_waddr  = d_idx;
    ram_wdata  = rdata & ~(EW'(1) << REF_BIT);
    unique case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[IW-1:0];
        ram_wdata = '0;
        if (cnt == LAST_W) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == REQ_ALLOC) ? S_SCAN : S_OPRD;
        end
      end
      S_SCAN: begin
        ram_re = (cnt < FRAMES_W);
        if (d_valid && (!r_used || ({1'b0, d_idx} == LAST_W))) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (free_found) begin
          state_next = S_COMMIT;
        end else if (policy == POL_SC && cand_found) begin
          state_next = (sc_end != '0) ? S_SWEEP : S_VREAD;
        end else if (policy == POL_AGE && ag_found) begin
          state_next = S_VREAD;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_SWEEP: begin
        ram_re = (cnt < clr_end);
        ram_we = d_valid && r_cand && r_ref;
        if (sweep_last) begin
          state_next = S_VREAD;
        end
      end
      S_VREAD: begin
        ram_re     = 1'b1;
        ram_raddr  = pick;
        state_next = S_COMMIT;
      end
      S_OPRD: begin
        ram_re     = 1'b1;
        ram_raddr  = idx_addr;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        ram_we    = slot_free && (is_alloc ? (status_r != ST_NONE) : idx_ok);
        ram_waddr = is_alloc ? pick : idx_addr;
        ram_wdata = commit_entry;
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      cnt      <= '0;
      d_valid  <= 1'b0;
      m_tvalid <= 1'b0;
      policy   <= POL_SC;
    end else begin
      state   <= state_next;
      d_valid <= ram_re;
      d_idx   <= ram_raddr;

      if (psel && penable && pwrite && !paddr[2]) begin
        policy <= pwdata[1:0];
      end

      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLR: begin
          cnt <= cnt + (IW+1)'(1);
        end
        S_IDLE: begin
          if (accept) begin
            req_r      <= s_tuser;
            idx_r      <= s_tdata[5:0];
            kind_r     <= s_tdata[7:6];
            pin_r      <= s_tdata[8];
            owner_r    <= s_tdata[14:9];
            vpage_r    <= s_tdata[34:15];
            agev_r     <= s_tdata[50:35];
            cnt        <= '0;
            free_found <= 1'b0;
            cand_found <= 1'b0;
            sc_found   <= 1'b0;
            ag_found   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (ram_re) begin
            cnt <= cnt + (IW+1)'(1);
          end
          if (d_valid) begin
            if (!r_used) begin
              free_found <= 1'b1;
              free_idx   <= d_idx;
            end else if (r_cand) begin
              if (!cand_found) begin
                cand_found <= 1'b1;
                first_idx  <= d_idx;
              end
              if (!r_ref && !sc_found) begin
                sc_found <= 1'b1;
                sc_idx   <= d_idx;
              end
              if (!ag_found || r_age < ag_age) begin
                ag_found <= 1'b1;
                ag_idx   <= d_idx;
                ag_age   <= r_age;
              end
            end
          end
        end
        S_DECIDE: begin
          cnt     <= '0;
          clr_end <= sc_end;
          if (free_found) begin
            pick     <= free_idx;
            status_r <= ST_FREE;
          end else if (policy == POL_SC && cand_found) begin
            pick     <= sc_found ? sc_idx : first_idx;
            status_r <= ST_VICTIM;
          end else if (policy == POL_AGE && ag_found) begin
            pick     <= ag_idx;
            status_r <= ST_VICTIM;
          end else begin
            pick     <= '0;
            status_r <= ST_NONE;
          end
        end
        S_SWEEP: begin
          if (ram_re) begin
            cnt <= cnt + (IW+1)'(1);
          end
        end
        S_COMMIT: begin
          if (commit) begin
            if (is_alloc) begin
              m_tuser <= status_r;
              m_tdata[5:0] <= (status_r == ST_NONE) ? 6'd0 : INDEX_W'(pick);
              m_tdata[11:6] <= (status_r == ST_VICTIM) ? r_owner : 6'd0;
              m_tdata[31:12] <= (status_r == ST_VICTIM) ? r_vpage : 20'd0;
            end else begin
              m_tuser        <= ST_ACK;
              m_tdata[5:0]   <= idx_r;
              m_tdata[11:6]  <= 6'd0;
              m_tdata[31:12] <= 20'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("block still ready after accepting a request");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("table written while idle");

  a_none_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_NONE) |-> (m_tdata == 32'd0))
    else $error("no-frame result carries a frame or eviction data");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (clr_end != '0 && status_r == ST_VICTIM))
    else $error("referenced-bit sweep entered without a victim");

  a_commit_from_read: assert property (@(posedge clk) disable iff (rst)
    ((state == S_COMMIT) && $past(state) == S_IDLE) |-> 1'b0)
    else $error("commit reached without a table read or scan");
`endif

endmodule

/* dv/frame_allocator_second_chance_aging_core_tb.sv */
// Self-checking testbench for the frame allocator with second-chance and aging replacement.
`timescale 1ns / 1ps

module frame_allocator_second_chance_aging_core_tb;
  import fasca_pkg::*;

  localparam int N_FRAMES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [2:0] ADDR_POLICY = 3'd0;
  localparam logic [POL_W-1:0] POL_NONE = 2'd2;
  localparam logic [POL_W-1:0] POL_NONE_ALT = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [INDEX_W-1:0] idx;
    logic [KIND_W-1:0]  kind;
    logic               pin;
    logic [OWNER_W-1:0] owner;
    logic [VPAGE_W-1:0] vpage;
    logic [AGEV_W-1:0]  agev;
  } request_t;

  typedef struct packed {
    logic [INDEX_W-1:0] frame;
    logic [STAT_W-1:0]  status;
    logic [OWNER_W-1:0] ev_owner;
    logic [VPAGE_W-1:0] ev_page;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted frame table.
  logic               used_tab  [N_FRAMES];
  logic [KIND_W-1:0]  kind_tab  [N_FRAMES];
  logic               pin_tab   [N_FRAMES];
  logic               ref_tab   [N_FRAMES];
  logic [AGEV_W-1:0]  age_tab   [N_FRAMES];
  logic [OWNER_W-1:0] owner_tab [N_FRAMES];
  logic [VPAGE_W-1:0] vpage_tab [N_FRAMES];
  logic [POL_W-1:0]   cur_policy;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  request_t next_req;
  request_t seen_req;
  logic     in_fire;
  logic     calm;
  int       mismatches;
  int       stall_cycles;

  frame_allocator_second_chance_aging_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_victim_candidate(int f);
    return used_tab[f] && !pin_tab[f] && kind_tab[f] == KIND_PAGE;
  endfunction

  function automatic reply_t serve_request(request_t rq);
    reply_t rp;
    int     f;
    int     pick;
    int     first;
    rp.frame = rq.idx;
    rp.status = ST_ACK;
    rp.ev_owner = '0;
    rp.ev_page = '0;
    if (rq.req == REQ_ALLOC) begin
      pick = N_FRAMES;
      for (f = 0; f < N_FRAMES; f++) begin
        if (!used_tab[f] && pick == N_FRAMES) pick = f;
      end
      rp.status = ST_FREE;
      if (pick == N_FRAMES) begin
        if (cur_policy == POL_SC) begin
          first = N_FRAMES;
          for (f = 0; f < N_FRAMES && pick == N_FRAMES; f++) begin
            if (is_victim_candidate(f)) begin
              if (first == N_FRAMES) first = f;
              if (ref_tab[f]) ref_tab[f] = 1'b0;
              else pick = f;
            end
          end
          if (pick == N_FRAMES) pick = first;
        end else if (cur_policy == POL_AGE) begin
          for (f = 0; f < N_FRAMES; f++) begin
            if (is_victim_candidate(f) && (pick == N_FRAMES || age_tab[f] < age_tab[pick]))
              pick = f;
          end
        end
        if (pick != N_FRAMES) begin
          rp.status = ST_VICTIM;
          rp.ev_owner = owner_tab[pick];
          rp.ev_page = vpage_tab[pick];
        end
      end
      if (pick == N_FRAMES) begin
        rp.status = ST_NONE;
        rp.frame = '0;
      end else begin
        used_tab[pick] = 1'b1;
        kind_tab[pick] = rq.kind;
        pin_tab[pick] = rq.pin;
        ref_tab[pick] = 1'b0;
        age_tab[pick] = '0;
        owner_tab[pick] = rq.owner;
        vpage_tab[pick] = rq.vpage;
        rp.frame = pick[INDEX_W-1:0];
      end
    end else if (rq.req == REQ_MARK) begin
      ref_tab[rq.idx] = 1'b1;
    end else if (rq.req == REQ_AGE) begin
      age_tab[rq.idx] = rq.agev;
    end else begin
      used_tab[rq.idx] = 1'b0;
      kind_tab[rq.idx] = '0;
      pin_tab[rq.idx] = 1'b0;
      ref_tab[rq.idx] = 1'b0;
      age_tab[rq.idx] = '0;
      owner_tab[rq.idx] = '0;
      vpage_tab[rq.idx] = '0;
    end
    return rp;
  endfunction

  function automatic request_t random_req(logic [REQ_W-1:0] req);
    request_t rq;
    rq.req = req;
    rq.idx = INDEX_W'($urandom_range(0, 63));
    rq.kind = KIND_W'($urandom_range(0, 3));
    rq.pin = 1'($urandom_range(0, 1));
    rq.owner = OWNER_W'($urandom_range(0, 63));
    rq.vpage = VPAGE_W'($urandom_range(0, 20'hFFFFF));
    rq.agev = AGEV_W'($urandom_range(0, 16'hFFFF));
    return rq;
  endfunction

  task automatic push_req(logic [REQ_W-1:0] req, int idx, int kind, int pin, int owner,
                          int vpage, int agev);
    request_t rq;
    rq.req = req;
    rq.idx = INDEX_W'(idx);
    rq.kind = KIND_W'(kind);
    rq.pin = pin[0];
    rq.owner = OWNER_W'(owner);
    rq.vpage = VPAGE_W'(vpage);
    rq.agev = AGEV_W'(agev);
    pending_reqs.push_back(rq);
  endtask

  task automatic mark_every_frame();
    request_t rq;
    for (int f = 0; f < N_FRAMES; f++) begin
      rq = random_req(REQ_MARK);
      rq.idx = INDEX_W'(f);
      pending_reqs.push_back(rq);
    end
  endtask

  task automatic add_page_allocs(int n);
    request_t rq;
    repeat (n) begin
      rq = random_req(REQ_ALLOC);
      rq.kind = KIND_PAGE;
      rq.pin = 1'b0;
      pending_reqs.push_back(rq);
    end
  endtask

  task automatic add_mixed(int n);
    request_t rq;
    int       i;
    int       r;
    i = 0;
    while (i < n) begin
      r = $urandom_range(0, 99);
      if (r == 99) begin
        mark_every_frame();
        i += N_FRAMES;
      end else begin
        if (r < 40) begin
          rq = random_req(REQ_ALLOC);
          if ($urandom_range(0, 4) != 0) rq.kind = KIND_PAGE;
          rq.pin = ($urandom_range(0, 99) < 12);
        end else if (r < 68) begin
          rq = random_req(REQ_MARK);
        end else if (r < 84) begin
          rq = random_req(REQ_AGE);
          if ($urandom_range(0, 1) != 0) rq.agev = AGEV_W'($urandom_range(0, 3));
        end else begin
          rq = random_req(REQ_RELEASE);
        end
        pending_reqs.push_back(rq);
        i++;
      end
    end
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (pending_reqs.size() != 0 || expected_replies.size() != 0 || s_tvalid);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_policy(logic [31:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_POLICY;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    cur_policy = value[POL_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reply(logic [31:0] data, logic [1:0] user);
    reply_t exp_rp;
    reply_t got;
    got.frame = data[5:0];
    got.ev_owner = data[11:6];
    got.ev_page = data[31:12];
    got.status = user;
    if (expected_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result beat: frame %0d status %0d owner %0d page %05h",
                 got.frame, got.status, got.ev_owner, got.ev_page);
    end else begin
      exp_rp = expected_replies.pop_front();
      if (got.frame !== exp_rp.frame || got.status !== exp_rp.status ||
          got.ev_owner !== exp_rp.ev_owner || got.ev_page !== exp_rp.ev_page) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result mismatch: expected frame %0d status %0d owner %0d page %05h",
                   exp_rp.frame, exp_rp.status, exp_rp.ev_owner, exp_rp.ev_page);
          $display("  got frame %0d status %0d owner %0d page %05h",
                   got.frame, got.status, got.ev_owner, got.ev_page);
        end
      end
    end
  endtask

  // Request driver.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
        next_req = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_req.req;
        s_tdata <= {5'b0, next_req.agev, next_req.vpage, next_req.owner, next_req.pin,
                    next_req.kind, next_req.idx};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(0, 99) >= 28);
  end

  // Monitor, predictor hookup and watchdog.
  always @(posedge clk) begin
    in_fire = s_tvalid && s_tready;
    if (!rst) begin
      if (in_fire) begin
        seen_req.req = s_tuser;
        {seen_req.agev, seen_req.vpage, seen_req.owner, seen_req.pin, seen_req.kind,
         seen_req.idx} = s_tdata[50:0];
        expected_replies.push_back(serve_request(seen_req));
      end
      if (m_tvalid && m_tready) check_reply(m_tdata, m_tuser);
      if (in_fire || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    request_t rq;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_fire = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    cur_policy = POL_SC;
    for (int f = 0; f < N_FRAMES; f++) begin
      used_tab[f] = 1'b0;
      kind_tab[f] = '0;
      pin_tab[f] = 1'b0;
      ref_tab[f] = 1'b0;
      age_tab[f] = '0;
      owner_tab[f] = '0;
      vpage_tab[f] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: requests on unused frames, field extremes, each kind, reuse after release.
    push_req(REQ_MARK, 0, 0, 0, 0, 0, 0);
    push_req(REQ_AGE, 63, 3, 1, 63, 20'hFFFFF, 16'hFFFF);
    push_req(REQ_RELEASE, 42, 3, 1, 63, 20'hFFFFF, 16'hFFFF);
    push_req(REQ_ALLOC, 63, 3, 1, 63, 20'hFFFFF, 16'hFFFF);
    push_req(REQ_ALLOC, 0, 0, 0, 0, 0, 0);
    push_req(REQ_ALLOC, 5, 1, 0, 17, 20'h12345, 0);
    push_req(REQ_ALLOC, 9, 2, 1, 33, 20'hABCDE, 0);
    push_req(REQ_MARK, 1, 0, 0, 0, 0, 0);
    push_req(REQ_AGE, 1, 0, 0, 0, 0, 16'h0001);
    push_req(REQ_RELEASE, 1, 0, 0, 0, 0, 0);
    push_req(REQ_ALLOC, 0, 0, 0, 5, 20'h00001, 0);
    push_req(REQ_RELEASE, 0, 0, 0, 0, 0, 0);

    write_policy({30'd0, POL_SC});
    add_page_allocs(N_FRAMES);
    mark_every_frame();
    add_page_allocs(2);
    add_mixed(260);

    write_policy({30'd0, POL_AGE});
    add_mixed(260);

    write_policy({30'd0, POL_NONE});
    add_mixed(110);

    write_policy({30'($urandom_range(0, 32'h3FFF_FFFF)), POL_NONE_ALT});
    add_mixed(110);

    // A full table with no data page left that may be replaced.
    write_policy({30'd0, POL_SC});
    for (int f = 0; f < N_FRAMES; f++) begin
      rq = random_req(REQ_RELEASE);
      rq.idx = INDEX_W'(f);
      pending_reqs.push_back(rq);
    end
    repeat (N_FRAMES) begin
      rq = random_req(REQ_ALLOC);
      if (rq.kind == KIND_PAGE) rq.pin = 1'b1;
      pending_reqs.push_back(rq);
    end
    repeat (12) pending_reqs.push_back(random_req(REQ_ALLOC));
    repeat (8) pending_reqs.push_back(random_req(REQ_MARK));
    write_policy({30'd0, POL_AGE});
    repeat (12) pending_reqs.push_back(random_req(REQ_ALLOC));

    write_policy({30'd0, POL_AGE});
    calm = 1'b1;
    add_mixed(400);
    drain();
    @(posedge clk);
    calm = 1'b0;

    write_policy({30'd0, POL_SC});
    add_mixed(170);
    write_policy({30'd0, POL_AGE});
    add_mixed(170);
    write_policy({30'd0, POL_SC});
    add_mixed(170);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* frame_allocator_second_chance_aging_core.f */
hdl/fasca_pkg.sv
hdl/fasca_ram.sv
hdl/frame_allocator_second_chance_aging_core.sv
dv/frame_allocator_second_chance_aging_core_tb.sv
